// File: hw/rtl/aes_pkg.sv
// Shared types, constants and GF(2^8) helpers for the AES block cipher.
// Used by the key expander, the round stages and the top level.
`default_nettype none

package aes_pkg;

    localparam int STORE_DEPTH = 60;
    localparam int MAX_ROUNDS  = 14;
    localparam int KEY_BITS    = 256;

    typedef logic [255:0][7:0] sbox_t;
    typedef logic [0:15][7:0]  state_t;
    typedef logic [0:7][31:0]  key_words_t;

    typedef enum logic [2:0] {
        REG_KEY0 = 3'd0,
        REG_KEY1 = 3'd1,
        REG_KEY2 = 3'd2,
        REG_KEY3 = 3'd3,
        REG_KLEN = 3'd4,
        REG_DIR  = 3'd5
    } cfg_reg_e;

    typedef struct packed {
        key_words_t key;
        logic [1:0] key_len;
        logic       dir;
        logic       start;
    } kx_ctl_t;

    typedef struct packed {
        logic [3:0] nr;
        logic       dir;
    } rnd_ctl_t;

    function automatic logic [7:0] rotl8(logic [7:0] x, int n);
        return (x << n) | (x >> (8 - n));
    endfunction

    function automatic sbox_t gen_sbox();
        logic [7:0] p;
        logic [7:0] q;
        logic [7:0] t;
        sbox_t      s;
        p = 8'h01;
        q = 8'h01;
        s = '0;
        for (int n = 0; n < 255; n++) begin
            t = p ^ (p << 1) ^ (p[7] ? 8'h1b : 8'h00);
            p = t;
            q = q ^ (q << 1);
            q = q ^ (q << 2);
            q = q ^ (q << 4);
            if (q[7]) q = q ^ 8'h09;
            s[p] = q ^ rotl8(q, 1) ^ rotl8(q, 2) ^ rotl8(q, 3) ^ rotl8(q, 4) ^ 8'h63;
        end
        s[0] = 8'h63;
        return s;
    endfunction

    function automatic sbox_t gen_inv(sbox_t s);
        sbox_t v;
        v = '0;
        for (int i = 0; i < 256; i++) v[s[i]] = 8'(i);
        return v;
    endfunction

    localparam sbox_t SBOX     = gen_sbox();
    localparam sbox_t INV_SBOX = gen_inv(SBOX);

    function automatic logic [7:0] xtime(logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gmul(logic [7:0] a, logic [3:0] b);
        logic [7:0] r;
        logic [7:0] x;
        r = '0;
        x = a;
        for (int k = 0; k < 4; k++) begin
            if (b[k]) r = r ^ x;
            x = xtime(x);
        end
        return r;
    endfunction

    function automatic logic [31:0] mix_word(logic [31:0] w);
        logic [7:0] a0, a1, a2, a3;
        a0 = w[31:24]; a1 = w[23:16]; a2 = w[15:8]; a3 = w[7:0];
        return {gmul(a0, 4'd2) ^ gmul(a1, 4'd3) ^ a2 ^ a3,
                a0 ^ gmul(a1, 4'd2) ^ gmul(a2, 4'd3) ^ a3,
                a0 ^ a1 ^ gmul(a2, 4'd2) ^ gmul(a3, 4'd3),
                gmul(a0, 4'd3) ^ a1 ^ a2 ^ gmul(a3, 4'd2)};
    endfunction

    function automatic logic [31:0] inv_mix_word(logic [31:0] w);
        logic [7:0] a0, a1, a2, a3;
        a0 = w[31:24]; a1 = w[23:16]; a2 = w[15:8]; a3 = w[7:0];
        return {gmul(a0, 4'd14) ^ gmul(a1, 4'd11) ^ gmul(a2, 4'd13) ^ gmul(a3, 4'd9),
                gmul(a0, 4'd9) ^ gmul(a1, 4'd14) ^ gmul(a2, 4'd11) ^ gmul(a3, 4'd13),
                gmul(a0, 4'd13) ^ gmul(a1, 4'd9) ^ gmul(a2, 4'd14) ^ gmul(a3, 4'd11),
                gmul(a0, 4'd11) ^ gmul(a1, 4'd13) ^ gmul(a2, 4'd9) ^ gmul(a3, 4'd14)};
    endfunction

    function automatic logic [31:0] sub_word(logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/aes_key_expand.sv
// Key expansion sequencer: one round-key word per cycle into the key store.
// Depends on aes_pkg.
`default_nettype none

module aes_key_expand import aes_pkg::*; (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire kx_ctl_t ctl,
    output logic         busy,
    output logic [STORE_DEPTH-1:0][31:0] round_keys
);

    logic                        run_reg;
    logic [5:0]                  idx_reg;
    logic [2:0]                  mod_reg;
    logic [7:0]                  rcon_reg;
    logic [7:0][31:0]            win_reg;
    logic [STORE_DEPTH-1:0][31:0] rk_reg;

    logic [3:0]  nk;
    logic [3:0]  nr;
    logic [5:0]  last_idx;
    logic [31:0] t;
    logic [31:0] word;
    logic [3:0]  q;
    logic        inner;
    logic [5:0]  wr_addr;
    logic [31:0] wr_data;
    logic [2:0]  nk_m1;

    always_comb begin
        case (ctl.key_len)
            2'd0:    nk = 4'd4;
            2'd1:    nk = 4'd6;
            default: nk = 4'd8;
        endcase
        nr       = nk + 4'd6;
        last_idx = {nr, 2'b11};
        nk_m1    = 3'(nk - 4'd1);
        t        = win_reg[0];
        if (mod_reg == 3'd0) begin
            t = sub_word({win_reg[0][23:0], win_reg[0][31:24]}) ^ {rcon_reg, 24'h0};
        end else if (nk == 4'd8 && mod_reg == 3'd4) begin
            t = sub_word(win_reg[0]);
        end
        word    = (idx_reg < {2'b00, nk}) ? ctl.key[idx_reg[2:0]] : (win_reg[nk_m1] ^ t);
        q       = idx_reg[5:2];
        inner   = (q != 4'd0) && (q != nr);
        wr_addr = ctl.dir ? {nr - q, idx_reg[1:0]} : idx_reg;
        wr_data = (ctl.dir && inner) ? inv_mix_word(word) : word;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg <= 1'b0;
        end else if (ctl.start) begin
            run_reg <= 1'b1;
        end else if (run_reg && idx_reg == last_idx) begin
            run_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.start) begin
            idx_reg  <= '0;
            mod_reg  <= '0;
            rcon_reg <= 8'h01;
        end else if (run_reg) begin
            idx_reg <= idx_reg + 6'd1;
            mod_reg <= (mod_reg == nk_m1) ? 3'd0 : mod_reg + 3'd1;
            if (idx_reg >= {2'b00, nk} && mod_reg == 3'd0) rcon_reg <= xtime(rcon_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (run_reg && !ctl.start) begin
            win_reg          <= {win_reg[6:0], word};
            rk_reg[wr_addr]  <= wr_data;
        end
    end

    assign busy       = run_reg | ctl.start;
    assign round_keys = rk_reg;

endmodule

`default_nettype wire

// File: hw/rtl/aes_round.sv
// One pipeline stage: key add, full round, last round or pass-through.
// Depends on aes_pkg.
`default_nettype none

module aes_round import aes_pkg::*; #(
    parameter int ROUND = 1
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire rnd_ctl_t ctl,
    input  wire state_t   rkey,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire state_t   in_state,
    input  wire logic     in_last,
    output logic          out_valid,
    input  wire logic     out_ready,
    output state_t        out_state,
    output logic          out_last
);

    logic   valid_reg;
    state_t state_reg;
    logic   last_reg;
    state_t sub;
    state_t mixed;
    state_t state_next;

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                if (ctl.dir) sub[4*c+r] = INV_SBOX[in_state[4*((c-r)&3)+r]];
                else         sub[4*c+r] = SBOX[in_state[4*((c+r)&3)+r]];
            end
        end
        for (int c = 0; c < 4; c++) begin
            if (ctl.dir) mixed[4*c +: 4] = inv_mix_word(sub[4*c +: 4]);
            else         mixed[4*c +: 4] = mix_word(sub[4*c +: 4]);
        end
        if (ROUND == 0) begin
            state_next = in_state ^ rkey;
        end else if (4'(ROUND) > ctl.nr) begin
            state_next = in_state;
        end else if (4'(ROUND) == ctl.nr) begin
            state_next = sub ^ rkey;
        end else begin
            state_next = mixed ^ rkey;
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            state_reg <= state_next;
            last_reg  <= in_last;
        end
    end

    assign out_valid = valid_reg;
    assign out_state = state_reg;
    assign out_last  = last_reg;

endmodule

`default_nettype wire

// File: hw/rtl/aes_block_cipher.sv
// AES-128/192/256 block cipher: config registers, key expander, round pipeline.
// Depends on aes_pkg, aes_key_expand and aes_round.
//
// Usage
//   Configuration: cfg_wr_en writes cfg_wr_data to register cfg_addr (0..3 key
//   words, 4 key length, 5 direction). Each write to one of them restarts
//   key expansion of 4*(rounds+1) words (44, 52 or 60); s_ready is low
//   meanwhile. Write configuration only while the pipeline is empty.
//   Input: s_valid/s_ready transfer one 128-bit block and its last flag.
//   Output: m_valid/m_ready transfer the result and the copied flag.
//   Path: each block passes all 15 registered stages, whatever the key
//   length; rounds beyond the key's count pass the state through.
//   Throughput: one block per cycle if m_ready is high and no expansion runs.
//   Stall: a full stage holds while its successor is not ready, so bubbles close up
//   and input continues to be taken until the pipeline is full.
//   Reset: clears valid bits and configuration; the key store is undefined
//   until the first configuration write.
`default_nettype none

module aes_block_cipher import aes_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_addr,
    input  wire logic [63:0] cfg_wr_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [63:0] s_block_hi,
    input  wire logic [63:0] s_block_lo,
    input  wire logic        s_last_block,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [63:0]      m_result_hi,
    output logic [63:0]      m_result_lo,
    output logic             m_last_out
);

    logic [0:3][63:0] key_reg;
    logic [1:0]       klen_reg;
    logic             dir_reg;
    logic             start_reg;

    kx_ctl_t  kx_ctl;
    rnd_ctl_t rnd_ctl;
    logic     busy;
    logic [STORE_DEPTH-1:0][31:0] round_keys;

    logic   vld [0:MAX_ROUNDS+1];
    logic   rdy [0:MAX_ROUNDS+1];
    state_t st  [0:MAX_ROUNDS+1];
    logic   lst [0:MAX_ROUNDS+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg   <= '0;
            klen_reg  <= '0;
            dir_reg   <= 1'b0;
            start_reg <= 1'b0;
        end else begin
            start_reg <= 1'b0;
            if (cfg_wr_en) begin
                case (cfg_reg_e'(cfg_addr))
                    REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3: begin
                        key_reg[cfg_addr[1:0]] <= cfg_wr_data;
                        start_reg <= 1'b1;
                    end
                    REG_KLEN: begin
                        klen_reg  <= cfg_wr_data[1:0];
                        start_reg <= 1'b1;
                    end
                    REG_DIR: begin
                        dir_reg   <= cfg_wr_data[0];
                        start_reg <= 1'b1;
                    end
                    default: start_reg <= 1'b0;
                endcase
            end
        end
    end

    assign kx_ctl.key     = key_reg;
    assign kx_ctl.key_len = klen_reg;
    assign kx_ctl.dir     = dir_reg;
    assign kx_ctl.start   = start_reg;

    assign rnd_ctl.nr  = (klen_reg == 2'd0) ? 4'd10 : ((klen_reg == 2'd1) ? 4'd12 : 4'd14);
    assign rnd_ctl.dir = dir_reg;

    aes_key_expand u_kx (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (kx_ctl),
        .busy       (busy),
        .round_keys (round_keys)
    );

    assign vld[0]  = s_valid && !busy;
    assign s_ready = rdy[0] && !busy;
    assign st[0]   = {s_block_hi, s_block_lo};
    assign lst[0]  = s_last_block;
    assign rdy[MAX_ROUNDS+1] = m_ready;

    for (genvar k = 0; k <= MAX_ROUNDS; k++) begin : g_stage
        aes_round #(.ROUND(k)) u_round (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctl       (rnd_ctl),
            .rkey      ({round_keys[4*k], round_keys[4*k+1],
                         round_keys[4*k+2], round_keys[4*k+3]}),
            .in_valid  (vld[k]),
            .in_ready  (rdy[k]),
            .in_state  (st[k]),
            .in_last   (lst[k]),
            .out_valid (vld[k+1]),
            .out_ready (rdy[k+1]),
            .out_state (st[k+1]),
            .out_last  (lst[k+1])
        );
    end

    assign m_valid     = vld[MAX_ROUNDS+1];
    assign m_result_hi = st[MAX_ROUNDS+1][0:7];
    assign m_result_lo = st[MAX_ROUNDS+1][8:15];
    assign m_last_out  = lst[MAX_ROUNDS+1];

endmodule

`default_nettype wire

// File: hw/rtl/aes_checker.sv
// Port-level checks for aes_block_cipher, bound to the top level.
// Depends on aes_pkg.
`default_nettype none

module aes_block_cipher_props import aes_pkg::*; (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        cfg_wr_en,
    input wire logic [2:0]  cfg_addr,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [63:0] m_result_hi,
    input wire logic [63:0] m_result_lo,
    input wire logic        m_last_out
);

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("output valid after reset");

    a_cfg_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (cfg_wr_en && cfg_addr <= REG_DIR) |=> !s_ready)
        else $error("input taken during key expansion");

    a_cfg_busy2: assert property (@(posedge aclk) disable iff (!aresetn)
        (cfg_wr_en && cfg_addr <= REG_DIR) |=> ##1 !s_ready)
        else $error("input taken before expansion finished");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_result_hi)
                                   && $stable(m_result_lo) && $stable(m_last_out)))
        else $error("stalled transfer changed");

endmodule

bind aes_block_cipher aes_block_cipher_props u_chk (.*);

`default_nettype wire
